// ===== sv/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

    localparam int COUNT_BITS = 16;
    localparam int VALUE_BITS = 32;
    localparam int CHAR_BITS  = 21;
    localparam int BASE_BITS  = 6;
    localparam int PROD_BITS  = VALUE_BITS + BASE_BITS + 1;

    typedef logic [CHAR_BITS-1:0]  t_char;
    typedef logic [BASE_BITS-1:0]  t_base;
    typedef logic [VALUE_BITS-1:0] t_mag;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_base MAX_RADIX = t_base'(36);
    localparam t_base HEX_RADIX = t_base'(16);
    localparam t_base DEC_RADIX = t_base'(10);
    localparam t_base OCT_RADIX = t_base'(8);
    localparam t_base NO_DIGIT  = '1;
    localparam t_base LETTER_OFFSET = t_base'(10);

    localparam t_mag HALF_RANGE = {1'b1, {(VALUE_BITS-1){1'b0}}};

    localparam t_char CH_TAB   = t_char'('h09);
    localparam t_char CH_LF    = t_char'('h0A);
    localparam t_char CH_VT    = t_char'('h0B);
    localparam t_char CH_FF    = t_char'('h0C);
    localparam t_char CH_CR    = t_char'('h0D);
    localparam t_char CH_SPACE = t_char'('h20);
    localparam t_char CH_PLUS  = t_char'('h2B);
    localparam t_char CH_MINUS = t_char'('h2D);
    localparam t_char CH_ZERO  = t_char'('h30);
    localparam t_char CH_NINE  = t_char'('h39);
    localparam t_char CH_UP_A  = t_char'('h41);
    localparam t_char CH_UP_X  = t_char'('h58);
    localparam t_char CH_UP_Z  = t_char'('h5A);
    localparam t_char CH_LO_A  = t_char'('h61);
    localparam t_char CH_LO_X  = t_char'('h78);
    localparam t_char CH_LO_Z  = t_char'('h7A);

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGNED,
        PH_DIGITS,
        PH_XPREFIX,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        t_count                       consumed;
        logic                         overflowed;
        logic                         found_digits;
    } t_result;

    function automatic t_base digit_of(input t_char c);
        t_base d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = t_base'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = t_base'(c - CH_LO_A) + LETTER_OFFSET;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = t_base'(c - CH_UP_A) + LETTER_OFFSET;
        end
        return d;
    endfunction

    function automatic t_count count_inc(input t_count c);
        return (c == '1) ? c : t_count'(c + 1'b1);
    endfunction

endpackage

// ===== sv/itp_char_if.sv =====
`timescale 1ns / 1ps

interface itp_char_if import itp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char ch;
    logic  last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

// ===== sv/itp_result_if.sv =====
`timescale 1ns / 1ps

interface itp_result_if import itp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    t_count                       consumed;
    logic                         overflowed;
    logic                         found_digits;

    modport source (
        output valid, output value, output consumed, output overflowed,
        output found_digits, input ready
    );
    modport sink (
        input valid, input value, input consumed, input overflowed,
        input found_digits, output ready
    );
endinterface

// ===== sv/itp_cfg_if.sv =====
`timescale 1ns / 1ps

interface itp_cfg_if import itp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_base number_base;

    modport source (output valid, output number_base, input ready);
    modport sink (input valid, input number_base, output ready);
endinterface

// ===== sv/itp_mac.sv =====
`timescale 1ns / 1ps

module itp_mac import itp_pkg::*; (
    input  t_mag  i_magnitude,
    input  t_base i_base,
    input  t_base i_digit,
    input  logic  i_negative,
    output t_mag  o_product,
    output logic  o_over
);

    logic [PROD_BITS-1:0] w_prod;
    t_mag                 w_limit;

    assign w_prod    = PROD_BITS'(i_magnitude) * PROD_BITS'(i_base) + PROD_BITS'(i_digit);
    assign w_limit   = i_negative ? HALF_RANGE : t_mag'(HALF_RANGE - 1'b1);
    assign o_over    = w_prod > PROD_BITS'(w_limit);
    assign o_product = w_prod[VALUE_BITS-1:0];

endmodule

// ===== sv/itp_core.sv =====
`timescale 1ns / 1ps

module itp_core import itp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_char   i_ch,
    input  logic    i_last,
    input  t_base   i_number_base,
    output logic    o_due,
    output t_result o_result
);

    t_phase r_phase;
    t_mag   r_magnitude;
    logic   r_negative;
    t_base  r_active_base;
    t_count r_position;
    logic   r_overflow_seen;
    logic   r_zero_pending;

    t_phase w_phase;
    t_mag   w_magnitude;
    logic   w_negative;
    t_base  w_active_base;
    t_count w_position;
    logic   w_overflow_seen;
    logic   w_zero_pending;
    logic   w_due;
    logic   w_found;
    logic   w_accept;

    t_base  w_digit;
    t_base  w_first_base;
    t_base  w_first_radix;
    t_base  w_mac_base;
    t_mag   w_product;
    logic   w_over;
    logic   w_is_space;
    logic   w_is_sign;
    logic   w_is_x;

    t_mag   w_signed_mag;

    assign w_digit    = digit_of(i_ch);
    assign w_is_space = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_LF) ||
                        (i_ch == CH_FF) || (i_ch == CH_CR) || (i_ch == CH_VT);
    assign w_is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
    assign w_is_x     = (i_ch == CH_LO_X) || (i_ch == CH_UP_X);

    assign w_first_base  = (r_phase == PH_WS) ? i_number_base : r_active_base;
    assign w_first_radix = (w_first_base != '0) ? w_first_base :
                           ((i_ch == CH_ZERO) ? OCT_RADIX : DEC_RADIX);

    always_comb begin
        unique case (r_phase)
            PH_XPREFIX: w_mac_base = HEX_RADIX;
            PH_DIGITS:  w_mac_base = r_active_base;
            default:    w_mac_base = w_first_radix;
        endcase
    end

    itp_mac u_mac (
        .i_magnitude (r_magnitude),
        .i_base      (w_mac_base),
        .i_digit     (w_digit),
        .i_negative  (r_negative),
        .o_product   (w_product),
        .o_over      (w_over)
    );

    // next state
    always_comb begin
        w_phase         = r_phase;
        w_magnitude     = r_magnitude;
        w_negative      = r_negative;
        w_active_base   = r_active_base;
        w_position      = r_position;
        w_overflow_seen = r_overflow_seen;
        w_zero_pending  = r_zero_pending;
        w_due           = 1'b0;
        w_found         = 1'b0;
        w_accept        = 1'b0;

        unique case (r_phase)
            PH_WS, PH_SIGNED: begin
                if (r_phase == PH_WS && w_is_space) begin
                    w_active_base = i_number_base;
                    w_position    = count_inc(r_position);
                end else if (r_phase == PH_WS && w_is_sign) begin
                    w_active_base = i_number_base;
                    w_negative    = (i_ch == CH_MINUS);
                    w_position    = count_inc(r_position);
                    w_phase       = PH_SIGNED;
                end else if (w_first_base > MAX_RADIX) begin
                    w_active_base = w_first_base;
                    w_due         = 1'b1;
                end else if (i_ch == CH_ZERO &&
                             (w_first_base == '0 || w_first_base == HEX_RADIX)) begin
                    w_active_base  = w_first_radix;
                    w_accept       = 1'b1;
                    w_zero_pending = 1'b1;
                    w_phase        = PH_DIGITS;
                end else begin
                    w_active_base = w_first_radix;
                    if (w_digit < w_first_radix) begin
                        w_accept = 1'b1;
                        w_phase  = PH_DIGITS;
                    end else begin
                        w_due = 1'b1;
                    end
                end
            end
            PH_DIGITS: begin
                w_zero_pending = 1'b0;
                if (r_zero_pending && w_is_x) begin
                    w_active_base = HEX_RADIX;
                    w_phase       = PH_XPREFIX;
                end else if (w_digit < r_active_base) begin
                    w_accept = 1'b1;
                end else begin
                    w_due   = 1'b1;
                    w_found = 1'b1;
                end
            end
            PH_XPREFIX: begin
                if (w_digit < HEX_RADIX) begin
                    w_position = count_inc(r_position);
                    w_accept   = 1'b1;
                    w_phase    = PH_DIGITS;
                end else begin
                    w_due   = 1'b1;
                    w_found = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_accept) begin
            if (!r_overflow_seen) begin
                if (w_over) begin
                    w_overflow_seen = 1'b1;
                end else begin
                    w_magnitude = w_product;
                end
            end
            w_position = count_inc(w_position);
        end

        if (!w_due && i_last && r_phase != PH_DONE) begin
            w_due   = 1'b1;
            w_found = (w_phase == PH_DIGITS) || (w_phase == PH_XPREFIX);
        end
    end

    // result
    always_comb begin
        w_signed_mag = w_negative ? t_mag'(~w_magnitude + 1'b1) : w_magnitude;
        o_due        = w_due;
        o_result     = '0;
        if (w_found) begin
            if (w_overflow_seen) begin
                o_result.value = w_negative ? $signed(HALF_RANGE)
                                            : $signed(t_mag'(HALF_RANGE - 1'b1));
            end else begin
                o_result.value = $signed(w_signed_mag);
            end
            o_result.consumed     = w_position;
            o_result.overflowed   = w_overflow_seen;
            o_result.found_digits = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_phase         <= PH_WS;
            r_magnitude     <= '0;
            r_negative      <= 1'b0;
            r_active_base   <= '0;
            r_position      <= '0;
            r_overflow_seen <= 1'b0;
            r_zero_pending  <= 1'b0;
        end else if (i_fire) begin
            r_phase         <= w_due ? PH_DONE : w_phase;
            r_magnitude     <= w_magnitude;
            r_negative      <= w_negative;
            r_active_base   <= w_active_base;
            r_position      <= w_position;
            r_overflow_seen <= w_overflow_seen;
            r_zero_pending  <= w_zero_pending;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> r_phase == PH_WS)
        else $error("string end did not restart the parser");

    a_done_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |-> !o_due)
        else $error("second result for one string");

    a_overflow_needs_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_due && o_result.overflowed |-> o_result.found_digits)
        else $error("overflow flagged without digits");

    a_digits_consume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_due && o_result.found_digits |-> o_result.consumed != '0)
        else $error("digits found but nothing consumed");

endmodule

// ===== sv/integer_text_parser_top.sv =====
`timescale 1ns / 1ps
// Path: the character that ends a number passes the input register, then the result register,
// before its result is valid on o_result.
// Throughput: one character per cycle, with a stall only while a result waits on o_result.
// Reset: synchronous, active low; clears parse state and both valid flags,
// and sets number_base back to 10.

module integer_text_parser_top import itp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itp_char_if.sink     i_char,
    itp_cfg_if.sink      i_cfg,
    itp_result_if.source o_result
);

    logic    r_in_valid;
    t_char   r_in_ch;
    logic    r_in_last;
    t_base   r_number_base;
    logic    r_out_valid;
    t_result r_out;

    logic    w_fire;
    logic    w_due;
    logic    w_out_free;
    t_result w_result;

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_fire       = r_in_valid && (!w_due || w_out_free);
    assign i_char.ready = !r_in_valid || w_fire;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= DEC_RADIX;
        end else if (i_cfg.valid) begin
            r_number_base <= i_cfg.number_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_ch   <= i_char.ch;
            r_in_last <= i_char.last;
        end
    end

    itp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_ch          (r_in_ch),
        .i_last        (r_in_last),
        .i_number_base (r_number_base),
        .o_due         (w_due),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_due) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_due) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.value        = r_out.value;
    assign o_result.consumed     = r_out.consumed;
    assign o_result.overflowed   = r_out.overflowed;
    assign o_result.found_digits = r_out.found_digits;

endmodule

// ===== test/itp_parse_checker.sv =====
`timescale 1ns / 1ps

module itp_parse_checker import itp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    itp_char_if   i_char,
    itp_cfg_if    i_cfg,
    itp_result_if i_result,
    output int    o_fail_count,
    output int    o_pending
);

    localparam t_base       AUTO_RADIX = t_base'(0);
    localparam logic [63:0] HALF       = 64'd1 << (VALUE_BITS - 1);

    t_phase      scan_phase;
    logic [63:0] accum;
    logic        is_neg;
    t_base       cur_radix;
    t_base       radix_reg;
    t_count      char_pos;
    logic        saturated;
    logic        lead_zero;
    t_result     expected_q[$];
    int          fails = 0;

    function automatic t_base char_value(input t_char c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return t_base'(c - CH_ZERO);
        end
        if (c >= CH_LO_A && c <= CH_LO_Z) begin
            return t_base'(c - CH_LO_A + 10);
        end
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return t_base'(c - CH_UP_A + 10);
        end
        return NO_DIGIT;
    endfunction

    function automatic logic is_blank(input t_char c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_FF ||
               c == CH_CR || c == CH_VT;
    endfunction

    function automatic t_count bump(input t_count c);
        t_count full;
        full = '1;
        return (c == full) ? c : t_count'(c + 1'b1);
    endfunction

    function automatic void clear_string();
        scan_phase = PH_WS;
        accum      = '0;
        is_neg     = 1'b0;
        cur_radix  = '0;
        char_pos   = '0;
        saturated  = 1'b0;
        lead_zero  = 1'b0;
    endfunction

    function automatic void take_digit(input t_base d);
        logic [63:0] lim;
        lim = is_neg ? HALF : HALF - 1;
        if (!saturated) begin
            if (64'(d) > lim || accum > (lim - 64'(d)) / 64'(cur_radix)) begin
                saturated = 1'b1;
            end else begin
                accum = accum * 64'(cur_radix) + 64'(d);
            end
        end
        char_pos = bump(char_pos);
    endfunction

    function automatic logic start_number(input t_char c);
        t_base d;
        if (cur_radix > MAX_RADIX) begin
            return 1'b1;
        end
        if (c == CH_ZERO && (cur_radix == AUTO_RADIX || cur_radix == HEX_RADIX)) begin
            if (cur_radix == AUTO_RADIX) begin
                cur_radix = OCT_RADIX;
            end
            take_digit('0);
            lead_zero  = 1'b1;
            scan_phase = PH_DIGITS;
            return 1'b0;
        end
        if (cur_radix == AUTO_RADIX) begin
            cur_radix = DEC_RADIX;
        end
        d = char_value(c);
        if (d < cur_radix) begin
            take_digit(d);
            scan_phase = PH_DIGITS;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_parse(input t_char c, input logic fin);
        logic        due;
        logic        found;
        t_base       d;
        logic [63:0] val;
        t_result     r;
        due   = 1'b0;
        found = 1'b0;
        case (scan_phase)
            PH_WS: begin
                cur_radix = radix_reg;
                if (is_blank(c)) begin
                    char_pos = bump(char_pos);
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    is_neg     = (c == CH_MINUS);
                    char_pos   = bump(char_pos);
                    scan_phase = PH_SIGNED;
                end else begin
                    due = start_number(c);
                end
            end
            PH_SIGNED: begin
                due = start_number(c);
            end
            PH_DIGITS: begin
                if (lead_zero && (c == CH_LO_X || c == CH_UP_X)) begin
                    lead_zero  = 1'b0;
                    cur_radix  = HEX_RADIX;
                    scan_phase = PH_XPREFIX;
                end else begin
                    lead_zero = 1'b0;
                    d = char_value(c);
                    if (d < cur_radix) begin
                        take_digit(d);
                    end else begin
                        due   = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            PH_XPREFIX: begin
                d = char_value(c);
                if (d < HEX_RADIX) begin
                    char_pos = bump(char_pos);
                    take_digit(d);
                    scan_phase = PH_DIGITS;
                end else begin
                    due   = 1'b1;
                    found = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!due && fin && scan_phase != PH_DONE) begin
            due   = 1'b1;
            found = (scan_phase == PH_DIGITS || scan_phase == PH_XPREFIX);
        end
        if (due) begin
            val = '0;
            if (found) begin
                if (saturated) begin
                    val = is_neg ? HALF : HALF - 1;
                end else begin
                    val = is_neg ? -accum : accum;
                end
            end
            r.value        = val[VALUE_BITS-1:0];
            r.consumed     = found ? char_pos : '0;
            r.overflowed   = found && saturated;
            r.found_digits = found;
            expected_q.push_back(r);
            scan_phase = PH_DONE;
        end
        if (fin) begin
            clear_string();
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_string();
            radix_reg = DEC_RADIX;
            expected_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                radix_reg = i_cfg.number_base;
            end
            if (i_result.valid && i_result.ready) begin
                got.value        = i_result.value;
                got.consumed     = i_result.consumed;
                got.overflowed   = i_result.overflowed;
                got.found_digits = i_result.found_digits;
                if (expected_q.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected result: value %0d consumed %0d ovf %0b digits %0b",
                                 got.value, got.consumed, got.overflowed, got.found_digits);
                    end
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.value != want.value || got.consumed != want.consumed ||
                        got.overflowed != want.overflowed ||
                        got.found_digits != want.found_digits) begin
                        if (fails < 10) begin
                            $display("mismatch: expected value %0d consumed %0d ovf %0b digits %0b",
                                     want.value, want.consumed, want.overflowed,
                                     want.found_digits);
                            $display("          actual   value %0d consumed %0d ovf %0b digits %0b",
                                     got.value, got.consumed, got.overflowed,
                                     got.found_digits);
                        end
                        fails++;
                    end
                end
            end
            if (i_char.valid && i_char.ready) begin
                advance_parse(i_char.ch, i_char.last);
            end
        end
        o_pending    = expected_q.size();
        o_fail_count = fails;
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import itp_pkg::*;

    localparam int    QUIET_LIMIT    = 4000;
    localparam int    HOLD_CYCLES    = 300;
    localparam int    ITEMS_PER_MODE = 500;
    localparam t_base AUTO_RADIX     = t_base'(0);

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct = 27;
    int   recv_idle_pct = 71;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   fail_count;
    int   pending;

    t_char blanks[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    t_base base_list[9] = '{AUTO_RADIX, t_base'(1), t_base'(2), OCT_RADIX, DEC_RADIX,
                            HEX_RADIX, MAX_RADIX, t_base'(37), t_base'(63)};
    longint unsigned edges[7] = '{64'd0, 64'd1, 64'd1073741823, 64'd2147483647,
                                  64'd2147483648, 64'd2147483649, 64'd4294967295};

    itp_char_if   chars();
    itp_cfg_if    cfg();
    itp_result_if res();

    integer_text_parser_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (chars),
        .i_cfg    (cfg),
        .o_result (res)
    );

    itp_parse_checker u_parse_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (chars),
        .i_cfg        (cfg),
        .i_result     (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            res.ready   <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((chars.valid && chars.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_char digit_char(input int d);
        if (d < 10) begin
            return t_char'(CH_ZERO + d);
        end
        return t_char'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + d - 10);
    endfunction

    function automatic t_char noise_char();
        case ($urandom_range(0, 3))
            0: return t_char'($urandom_range(0, 1114111));
            1: return t_char'($urandom_range(0, 127));
            2: return t_char'($urandom_range(1048576, 1114111));
            default: return t_char'($urandom_range(0, 127)) | (t_char'(1) << $urandom_range(7, 20));
        endcase
    endfunction

    task automatic send_char(input t_char c, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            chars.valid <= 1'b0;
            @(posedge i_clk);
        end
        chars.valid <= 1'b1;
        chars.ch    <= c;
        chars.last  <= is_last;
        do @(posedge i_clk); while (!chars.ready);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(t_char'(s[i]), i == s.len() - 1);
        end
    endtask

    task automatic send_text(input t_char text[$]);
        foreach (text[i]) begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    task automatic settle();
        chars.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_base(input t_base b);
        settle();
        cfg.valid       <= 1'b1;
        cfg.number_base <= b;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic make_text(input t_base radix, output t_char text[$]);
        int              eff;
        int              n;
        int              kind;
        longint unsigned num;
        t_char           digs[$];
        text = {};
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 5)) text.push_back(noise_char());
            return;
        end
        repeat ($urandom_range(0, 2)) text.push_back(blanks[$urandom_range(0, 5)]);
        case ($urandom_range(0, 3))
            0: text.push_back(CH_PLUS);
            1: text.push_back(CH_MINUS);
            default: begin
            end
        endcase
        eff = (radix > MAX_RADIX) ? int'(DEC_RADIX) : int'(radix);
        if ((radix == AUTO_RADIX || radix == HEX_RADIX) && $urandom_range(0, 3) == 0) begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            eff = int'(HEX_RADIX);
        end else if (radix == AUTO_RADIX) begin
            if ($urandom_range(0, 1)) begin
                text.push_back(CH_ZERO);
                eff = int'(OCT_RADIX);
            end else begin
                eff = int'(DEC_RADIX);
            end
        end
        if (eff >= 2 && kind < 30) begin
            num = edges[$urandom_range(0, 6)];
            do begin
                digs.push_front(digit_char(int'(num % eff)));
                num = num / eff;
            end while (num != 0);
            foreach (digs[i]) text.push_back(digs[i]);
        end else begin
            n = (kind < 40) ? $urandom_range(8, 34) : $urandom_range(0, 6);
            repeat (n) text.push_back(digit_char($urandom_range(0, eff - 1)));
        end
        if ($urandom_range(0, 99) < 60) begin
            text.push_back(noise_char());
            repeat ($urandom_range(0, 3)) text.push_back(digit_char($urandom_range(0, 35)));
        end
        if (text.size() == 0) begin
            text.push_back(noise_char());
        end
    endtask

    initial begin
        t_char text[$];
        t_base radix;
        int    sent;
        int    seg;
        logic  pressured;
        chars.valid     <= 1'b0;
        chars.ch        <= '0;
        chars.last      <= 1'b0;
        cfg.valid       <= 1'b0;
        cfg.number_base <= '0;
        i_rst_n         <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (blanks[i]) send_char(blanks[i], 1'b0);
        send_str("+123");
        send_str("-2147483648");
        send_str("2147483647");
        send_str("2147483648");
        send_str("-99999999999");
        send_str("12a34");
        send_str("x");
        send_str("-");
        send_char(CH_NINE, 1'b0);
        send_char('0, 1'b0);
        send_char(CH_ZERO, 1'b1);
        send_char(t_char'(21'h10FFFF), 1'b1);
        send_char(CH_SPACE, 1'b1);
        write_base(HEX_RADIX);
        send_str("0x");
        send_str("0Xg");
        send_str("-0x80000000");
        send_str("0xFFFFFFFF");
        send_str("fF");
        write_base(AUTO_RADIX);
        send_str("0777");
        send_str("0x1a");
        send_str("09");
        send_str("-12");
        write_base(t_base'(1));
        send_str("001");
        write_base(t_base'(2));
        send_str("-1012");
        write_base(MAX_RADIX);
        send_str("zZ");
        send_str("-zzzzzzz");
        write_base(t_base'(37));
        send_str("5");
        write_base(t_base'(63));
        send_str("+1");
        write_base(DEC_RADIX);
        repeat (5) send_char(blanks[$urandom_range(0, 5)], 1'b0);
        send_str("7");

        seg       = 0;
        pressured = 1'b0;
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 71 : 0;
            recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 27 : 0;
            sent = 0;
            while (sent < ITEMS_PER_MODE) begin
                radix = (seg % 10 == 9) ? t_base'($urandom_range(0, 63)) : base_list[seg % 10];
                seg++;
                write_base(radix);
                if (mode == 2 && !pressured) begin
                    pressured = 1'b1;
                    hold_requests++;
                    repeat (40) send_char(digit_char($urandom_range(0, 9)), 1'b1);
                    sent += 40;
                end
                repeat ($urandom_range(4, 12)) begin
                    make_text(radix, text);
                    send_text(text);
                    sent += text.size();
                end
            end
        end

        chars.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
